[design/twodo_pkg.sv]
// Shared types, constants and the arctangent table for the tracking-wheel odometry unit.
package twodo_pkg;

  localparam int POS_FRAC_DEFAULT  = 8;
  localparam int TRIG_FRAC_DEFAULT = 16;

  localparam int HEADING_W = 16;
  localparam int COUNT_W   = 32;
  localparam int POS_W     = 48;
  localparam int DELTA_W   = COUNT_W + 2;
  localparam int ANGLE_W   = 32;
  localparam int CORDIC_W  = 33;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_ITERS = 30;
  localparam int ITER_W    = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [HEADING_W-1:0] HEADING_WRAP = 16'd36000;
  localparam logic [31:0] ANG_QUO   = 32'd119304;
  localparam logic [24:0] ANG_REM   = 25'd728;
  localparam logic [24:0] ANG_HALF  = 25'd562;
  localparam logic [51:0] ANG_RECIP = 52'd61083980;
  localparam int          ANG_RECIP_SH = 36;
  localparam logic signed [ANGLE_W-1:0] ANGLE_QUARTER = 32'sh4000_0000;
  localparam logic signed [ANGLE_W-1:0] ANGLE_NEG_QUARTER = 32'shC000_0000;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

  typedef struct packed {
    logic signed [DELTA_W-1:0] fwd2;
    logic signed [DELTA_W-1:0] lat2;
    logic signed [ANGLE_W-1:0] angle;
    logic                      flip;
  } odo_item_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL1,
    F_MUL2,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ROT,
    B_TRIG,
    B_MUL,
    B_SUM,
    B_ACC
  } back_state_t;

  function automatic logic signed [CORDIC_W-1:0] atan_angle(input logic [ITER_W-1:0] idx);
    logic signed [CORDIC_W-1:0] a;
    case (idx)
      5'd0:  a = 33'sd536870912;
      5'd1:  a = 33'sd316933406;
      5'd2:  a = 33'sd167458907;
      5'd3:  a = 33'sd85004756;
      5'd4:  a = 33'sd42667331;
      5'd5:  a = 33'sd21354465;
      5'd6:  a = 33'sd10679838;
      5'd7:  a = 33'sd5340245;
      5'd8:  a = 33'sd2670163;
      5'd9:  a = 33'sd1335087;
      5'd10: a = 33'sd667544;
      5'd11: a = 33'sd333772;
      5'd12: a = 33'sd166886;
      5'd13: a = 33'sd83443;
      5'd14: a = 33'sd41722;
      5'd15: a = 33'sd20861;
      5'd16: a = 33'sd10430;
      5'd17: a = 33'sd5215;
      5'd18: a = 33'sd2608;
      5'd19: a = 33'sd1304;
      5'd20: a = 33'sd652;
      5'd21: a = 33'sd326;
      5'd22: a = 33'sd163;
      5'd23: a = 33'sd81;
      5'd24: a = 33'sd41;
      5'd25: a = 33'sd20;
      5'd26: a = 33'sd10;
      5'd27: a = 33'sd5;
      5'd28: a = 33'sd3;
      5'd29: a = 33'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[design/twodo_front.sv]
// Front end: takes samples, forms count deltas and the folded binary heading angle.
module twodo_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [twodo_pkg::HEADING_W-1:0]       in_heading_centideg,
  input  logic signed [twodo_pkg::COUNT_W-1:0]  in_left_count,
  input  logic signed [twodo_pkg::COUNT_W-1:0]  in_right_count,
  input  logic signed [twodo_pkg::COUNT_W-1:0]  in_lateral_count,
  output logic                                  push,
  output twodo_pkg::odo_item_t                  push_item,
  input  logic                                  q_full
);
  import twodo_pkg::*;

  front_state_t state_r, state_nxt;

  logic signed [COUNT_W-1:0] last_left_r, last_right_r, last_lateral_r;
  logic signed [DELTA_W-1:0] fwd2_r, lat2_r;
  logic [HEADING_W-1:0]      hmod_r;
  logic [24:0]               v_r;
  logic [31:0]               a_r;
  logic [14:0]               q_r;

  logic                        accept;
  logic signed [COUNT_W:0]     dl, dr, dm;
  logic [HEADING_W-1:0]        hmod;
  logic [51:0]                 prod;
  logic [ANGLE_W-1:0]          zu;
  logic signed [ANGLE_W-1:0]   zs;
  logic                        fold;

  assign accept = in_valid && !in_stall;

  assign dl   = (COUNT_W+1)'(in_left_count) - (COUNT_W+1)'(last_left_r);
  assign dr   = (COUNT_W+1)'(in_right_count) - (COUNT_W+1)'(last_right_r);
  assign dm   = (COUNT_W+1)'(in_lateral_count) - (COUNT_W+1)'(last_lateral_r);
  assign hmod = (in_heading_centideg >= HEADING_WRAP) ?
                (in_heading_centideg - HEADING_WRAP) : in_heading_centideg;
  assign prod = {27'd0, v_r} * ANG_RECIP;

  assign zu   = a_r + {17'd0, q_r};
  assign zs   = signed'(zu);
  assign fold = (zs > ANGLE_QUARTER) || (zs < ANGLE_NEG_QUARTER);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) state_nxt = F_MUL1;
      end
      F_MUL1: state_nxt = F_MUL2;
      F_MUL2: state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    push     = 1'b0;
    case (state_r)
      F_IDLE:  in_stall = 1'b0;
      F_PUSH:  push = !q_full;
      default: ;
    endcase
  end

  always_comb begin
    push_item.fwd2  = fwd2_r;
    push_item.lat2  = lat2_r;
    push_item.angle = fold ? signed'({~zu[ANGLE_W-1], zu[ANGLE_W-2:0]}) : zs;
    push_item.flip  = fold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= F_IDLE;
      last_left_r    <= '0;
      last_right_r   <= '0;
      last_lateral_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        last_left_r    <= in_left_count;
        last_right_r   <= in_right_count;
        last_lateral_r <= in_lateral_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd2_r <= DELTA_W'(dl) + DELTA_W'(dr);
      lat2_r <= signed'({dm, 1'b0});
      hmod_r <= hmod;
    end
    if (state_r == F_MUL1) begin
      v_r <= 25'({9'd0, hmod_r} * ANG_REM) + ANG_HALF;
      a_r <= {16'd0, hmod_r} * ANG_QUO;
    end
    if (state_r == F_MUL2) begin
      q_r <= prod[ANG_RECIP_SH+14:ANG_RECIP_SH];
    end
  end

endmodule

[design/twodo_queue.sv]
// Short queue of classified samples between the front end and the rotation back end.
module twodo_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  twodo_pkg::odo_item_t push_item,
  output logic                 q_full,
  input  logic                 pop,
  output twodo_pkg::odo_item_t pop_item,
  output logic                 q_valid
);
  import twodo_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  odo_item_t           entries_r [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r;

  assign q_full   = (count_r == CntW'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign pop_item = entries_r[rd_ptr_r];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_item;
  end

endmodule

[design/twodo_back.sv]
// Back end: CORDIC sine and cosine, delta rotation, rounding and saturating accumulation.
module twodo_back #(
  parameter int POS_FRAC_BITS  = twodo_pkg::POS_FRAC_DEFAULT,
  parameter int TRIG_FRAC_BITS = twodo_pkg::TRIG_FRAC_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  twodo_pkg::odo_item_t                pop_item,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [twodo_pkg::POS_W-1:0]  out_pos_x,
  output logic signed [twodo_pkg::POS_W-1:0]  out_pos_y
);
  import twodo_pkg::*;

  localparam int RSH = CORDIC_FRAC - TRIG_FRAC_BITS;
  localparam int TW  = CORDIC_W - RSH;
  localparam int PW  = DELTA_W + TW;
  localparam int SW  = PW + 1;
  localparam int SH  = TRIG_FRAC_BITS + 1 - POS_FRAC_BITS;
  localparam int OW  = SW - SH;
  localparam int AW  = ((OW > POS_W) ? OW : POS_W) + 1;
  localparam logic signed [CORDIC_W-1:0] TRND = CORDIC_W'(1) <<< (RSH - 1);
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  back_state_t state_r, state_nxt;

  logic [ITER_W-1:0]          iter_r;
  logic signed [CORDIC_W-1:0] x_r, y_r, z_r;
  logic signed [DELTA_W-1:0]  fwd_r, lat_r;
  logic                       flip_r;
  logic signed [TW-1:0]       s_r, c_r;
  logic signed [PW-1:0]       p_fs_r, p_lc_r, p_fc_r, p_ls_r;
  logic signed [OW-1:0]       ox_r, oy_r;
  logic signed [POS_W-1:0]    acc_x_r, acc_y_r;
  logic                       out_valid_r;

  logic                       out_free, rot_en, trig_en, mul_en, sum_en, acc_en;
  logic signed [CORDIC_W-1:0] xs, ys, atan_i, xf, yf, c_sum, s_sum;
  logic signed [SW-1:0]       sum_x, sum_y;
  logic signed [OW-1:0]       ox_c, oy_c;
  logic signed [AW-1:0]       ax, ay;
  logic signed [POS_W-1:0]    nx, ny;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  assign xs     = x_r >>> iter_r;
  assign ys     = y_r >>> iter_r;
  assign atan_i = atan_angle(iter_r);

  assign xf    = flip_r ? -x_r : x_r;
  assign yf    = flip_r ? -y_r : y_r;
  assign c_sum = xf + TRND;
  assign s_sum = yf + TRND;

  assign sum_x = SW'(p_fs_r) + SW'(p_lc_r);
  assign sum_y = SW'(p_fc_r) - SW'(p_ls_r);

  if (SH > 0) begin : g_round
    localparam logic signed [SW:0] OHALF = (SW+1)'(1) <<< (SH - 1);
    logic signed [SW:0] rx, ry;
    assign rx   = (SW+1)'(sum_x) + OHALF;
    assign ry   = (SW+1)'(sum_y) + OHALF;
    assign ox_c = rx[SW-1:SH];
    assign oy_c = ry[SW-1:SH];
  end else if (SH == 0) begin : g_same
    assign ox_c = sum_x;
    assign oy_c = sum_y;
  end else begin : g_scale
    assign ox_c = signed'({sum_x, {(-SH){1'b0}}});
    assign oy_c = signed'({sum_y, {(-SH){1'b0}}});
  end

  assign ax = AW'(acc_x_r) + AW'(ox_r);
  assign ay = AW'(acc_y_r) + AW'(oy_r);

  always_comb begin
    nx = ax[POS_W-1:0];
    if (!ax[AW-1] && (|ax[AW-2:POS_W-1]))      nx = POS_MAX;
    else if (ax[AW-1] && !(&ax[AW-2:POS_W-1])) nx = POS_MIN;
    ny = ay[POS_W-1:0];
    if (!ay[AW-1] && (|ay[AW-2:POS_W-1]))      ny = POS_MAX;
    else if (ay[AW-1] && !(&ay[AW-2:POS_W-1])) ny = POS_MIN;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid) state_nxt = B_ROT;
      end
      B_ROT: begin
        if (iter_r == ITER_W'(CORDIC_ITERS - 1)) state_nxt = B_TRIG;
      end
      B_TRIG: state_nxt = B_MUL;
      B_MUL:  state_nxt = B_SUM;
      B_SUM:  state_nxt = B_ACC;
      B_ACC: begin
        if (out_free) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    rot_en  = 1'b0;
    trig_en = 1'b0;
    mul_en  = 1'b0;
    sum_en  = 1'b0;
    acc_en  = 1'b0;
    case (state_r)
      B_IDLE:  pop = q_valid;
      B_ROT:   rot_en = 1'b1;
      B_TRIG:  trig_en = 1'b1;
      B_MUL:   mul_en = 1'b1;
      B_SUM:   sum_en = 1'b1;
      B_ACC:   acc_en = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (pop)         iter_r <= '0;
      else if (rot_en) iter_r <= iter_r + 1'b1;
      if (acc_en) begin
        acc_x_r     <= nx;
        acc_y_r     <= ny;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= CORDIC_W'(pop_item.angle);
      fwd_r  <= pop_item.fwd2;
      lat_r  <= pop_item.lat2;
      flip_r <= pop_item.flip;
    end else if (rot_en) begin
      if (!z_r[CORDIC_W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_i;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_i;
      end
    end
    if (trig_en) begin
      c_r <= c_sum[CORDIC_W-1:RSH];
      s_r <= s_sum[CORDIC_W-1:RSH];
    end
    if (mul_en) begin
      p_fs_r <= PW'(fwd_r) * PW'(s_r);
      p_lc_r <= PW'(lat_r) * PW'(c_r);
      p_fc_r <= PW'(fwd_r) * PW'(c_r);
      p_ls_r <= PW'(lat_r) * PW'(s_r);
    end
    if (sum_en) begin
      ox_r <= ox_c;
      oy_r <= oy_c;
    end
    if (acc_en) begin
      out_pos_x <= nx;
      out_pos_y <= ny;
    end
  end

endmodule

[design/tracking_wheel_odometry_unit.sv]
// Top level of the tracking-wheel odometry unit: front end, sample queue and rotation back end.
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  heading_centideg, left/right/lateral_count
//  out_     output     out_valid/out_stall pos_x, pos_y (48-bit, saturating)
//
// The front end accepts a new sample only while idle, after pushing the last one; the back end
// works on one sample at a time and runs its 30 CORDIC iterations on a single shift-add unit.
// Synchronous active-low reset clears the stored counts, the position and the queue.
// A stalled result holds in the output register while the next samples queue up.
module tracking_wheel_odometry_unit #(
  parameter int POS_FRAC_BITS  = twodo_pkg::POS_FRAC_DEFAULT,
  parameter int TRIG_FRAC_BITS = twodo_pkg::TRIG_FRAC_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [twodo_pkg::HEADING_W-1:0]       in_heading_centideg,
  input  logic signed [twodo_pkg::COUNT_W-1:0]  in_left_count,
  input  logic signed [twodo_pkg::COUNT_W-1:0]  in_right_count,
  input  logic signed [twodo_pkg::COUNT_W-1:0]  in_lateral_count,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [twodo_pkg::POS_W-1:0]    out_pos_x,
  output logic signed [twodo_pkg::POS_W-1:0]    out_pos_y
);
  import twodo_pkg::*;

  odo_item_t push_item, pop_item;
  logic      push, pop, q_full, q_valid;

  twodo_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_heading_centideg (in_heading_centideg),
    .in_left_count       (in_left_count),
    .in_right_count      (in_right_count),
    .in_lateral_count    (in_lateral_count),
    .push                (push),
    .push_item           (push_item),
    .q_full              (q_full)
  );

  twodo_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_valid   (q_valid)
  );

  twodo_back #(
    .POS_FRAC_BITS  (POS_FRAC_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y)
  );

endmodule

[tb/sv/tracking_wheel_odometry_unit_test.sv]
// Self-checking testbench for the tracking-wheel odometry unit with its own position predictor.
module tracking_wheel_odometry_unit_test;
  import twodo_pkg::*;

  localparam int POS_FRAC  = POS_FRAC_DEFAULT;
  localparam int TRIG_FRAC = TRIG_FRAC_DEFAULT;
  localparam longint TURN       = 64'sd4294967296;
  localparam longint HALF_TURN  = 64'sd2147483648;
  localparam longint QUARTER    = 64'sd1073741824;
  localparam longint POS_MAX    = 64'sd140737488355327;
  localparam longint POS_MIN    = -64'sd140737488355328;
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 32'sh8000_0000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [HEADING_W-1:0]      heading;
    logic signed [COUNT_W-1:0] left;
    logic signed [COUNT_W-1:0] right;
    logic signed [COUNT_W-1:0] lateral;
  } reading_t;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } pos_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [HEADING_W-1:0] in_heading_centideg = '0;
  logic signed [COUNT_W-1:0] in_left_count = '0;
  logic signed [COUNT_W-1:0] in_right_count = '0;
  logic signed [COUNT_W-1:0] in_lateral_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [POS_W-1:0] out_pos_x;
  logic signed [POS_W-1:0] out_pos_y;

  reading_t reading_q[$];
  pos_t pos_expect_q[$];
  reading_t offered;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int n_sent = 0;
  int mismatch_count = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;

  longint prev_left = 0, prev_right = 0, prev_lateral = 0;
  longint pos_x = 0, pos_y = 0;

  logic signed [COUNT_W-1:0] gen_left = '0, gen_right = '0, gen_lateral = '0;

  longint atan_turn [0:29] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  tracking_wheel_odometry_unit #(
    .POS_FRAC_BITS (POS_FRAC),
    .TRIG_FRAC_BITS(TRIG_FRAC)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_heading_centideg(in_heading_centideg),
    .in_left_count      (in_left_count),
    .in_right_count     (in_right_count),
    .in_lateral_count   (in_lateral_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pos_x          (out_pos_x),
    .out_pos_y          (out_pos_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint round_to(input longint v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint to_pos_ticks(input longint v);
    int sh;
    sh = TRIG_FRAC + 1 - POS_FRAC;
    if (sh > 0) begin
      return round_to(v, sh);
    end
    return v * (64'sd1 <<< (-sh));
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v > POS_MAX) begin
      return POS_MAX;
    end
    if (v < POS_MIN) begin
      return POS_MIN;
    end
    return v;
  endfunction

  function automatic void heading_sin_cos(input logic [HEADING_W-1:0] hd,
                                          output longint s_q, output longint c_q);
    longint h, z, x, y, xs, ys;
    bit flip;
    h = longint'(hd) % 64'sd36000;
    z = (h * TURN + 64'sd18000) / 64'sd36000;
    flip = 1'b0;
    x = 64'sd652032874;
    y = 0;
    if (z >= HALF_TURN) begin
      z -= TURN;
    end
    if (z > QUARTER) begin
      z -= HALF_TURN;
      flip = 1'b1;
    end else if (z < -QUARTER) begin
      z += HALF_TURN;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= atan_turn[i];
      end else begin
        x += ys;
        y -= xs;
        z += atan_turn[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c_q = round_to(x, CORDIC_FRAC - TRIG_FRAC);
    s_q = round_to(y, CORDIC_FRAC - TRIG_FRAC);
  endfunction

  task automatic advance_position(input reading_t r);
    longint l, rt, m, fwd2, lat2, s, c;
    pos_t e;
    l = longint'(r.left);
    rt = longint'(r.right);
    m = longint'(r.lateral);
    fwd2 = (l - prev_left) + (rt - prev_right);
    lat2 = 2 * (m - prev_lateral);
    heading_sin_cos(r.heading, s, c);
    prev_left = l;
    prev_right = rt;
    prev_lateral = m;
    pos_x = clamp_pos(pos_x + to_pos_ticks(fwd2 * s + lat2 * c));
    pos_y = clamp_pos(pos_y + to_pos_ticks(fwd2 * c - lat2 * s));
    e.x = pos_x[POS_W-1:0];
    e.y = pos_y[POS_W-1:0];
    pos_expect_q.push_back(e);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        advance_position(offered);
        n_sent++;
      end
      if (reading_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = reading_q.pop_front();
        in_valid <= 1'b1;
        in_heading_centideg <= offered.heading;
        in_left_count <= offered.left;
        in_right_count <= offered.right;
        in_lateral_count <= offered.lateral;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_go || hold_left > 1 || $urandom_range(99) < stall_pct;
    end
  end

  always @(posedge clk) begin
    pos_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pos_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected transfer: pos_x=%0d pos_y=%0d", out_pos_x, out_pos_y);
        end
      end else begin
        e = pos_expect_q.pop_front();
        if (out_pos_x !== e.x || out_pos_y !== e.y) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected pos_x=%0d pos_y=%0d, got pos_x=%0d pos_y=%0d",
                     e.x, e.y, out_pos_x, out_pos_y);
          end
        end
      end
    end
  end

  task automatic push_reading(input logic [HEADING_W-1:0] h, input logic signed [COUNT_W-1:0] l,
                              input logic signed [COUNT_W-1:0] r,
                              input logic signed [COUNT_W-1:0] m);
    reading_t rd;
    rd.heading = h;
    rd.left = l;
    rd.right = r;
    rd.lateral = m;
    gen_left = l;
    gen_right = r;
    gen_lateral = m;
    reading_q.push_back(rd);
  endtask

  function automatic logic [HEADING_W-1:0] pick_heading();
    int k;
    k = $urandom_range(99);
    if (k < 85) begin
      return HEADING_W'($urandom_range(35999));
    end else if (k < 95) begin
      return HEADING_W'($urandom);
    end
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'd9000;
      2: return 16'd18000;
      3: return 16'd27000;
      4: return 16'd35999;
      5: return 16'd36000;
      6: return 16'hFFFF;
      default: return 16'd4500;
    endcase
  endfunction

  function automatic logic signed [COUNT_W-1:0] next_count(input logic signed [COUNT_W-1:0] c);
    int k;
    k = $urandom_range(99);
    if (k < 65) begin
      return c + (int'($urandom_range(4000)) - 2000);
    end else if (k < 85) begin
      return c + (int'($urandom_range(2097152)) - 1048576);
    end else if (k < 95) begin
      return $urandom;
    end
    case ($urandom_range(3))
      0: return COUNT_MAX;
      1: return COUNT_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic gen_mixed(input int n);
    for (int i = 0; i < n; i++) begin
      push_reading(pick_heading(), next_count(gen_left), next_count(gen_right),
                   next_count(gen_lateral));
    end
  endtask

  // Alternate extreme counts with a heading flip so every step pushes the same way.
  task automatic gen_runaway(input int n, input bit up);
    bit hi;
    for (int i = 0; i < n; i++) begin
      hi = (i % 2 == 0);
      push_reading((hi ^ up) ? 16'd18000 : 16'd0,
                   hi ? COUNT_MAX : COUNT_MIN, hi ? COUNT_MAX : COUNT_MIN,
                   hi ? COUNT_MAX : COUNT_MIN);
    end
  endtask

  task automatic wait_idle();
    while (reading_q.size() > 0 || in_valid || pos_expect_q.size() > 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    push_reading(16'd0, 32'sd0, 32'sd0, 32'sd0);
    push_reading(16'd0, 32'sd100, 32'sd100, 32'sd0);
    push_reading(16'd9000, 32'sd200, 32'sd200, 32'sd50);
    push_reading(16'd18000, 32'sd300, 32'sd301, 32'sd50);
    push_reading(16'd27000, 32'sd400, 32'sd400, -32'sd50);
    push_reading(16'd35999, 32'sd500, 32'sd500, -32'sd49);
    push_reading(16'd36000, 32'sd600, 32'sd601, -32'sd49);
    push_reading(16'hFFFF, 32'sd700, 32'sd700, 32'sd0);
    push_reading(16'd4500, 32'sd700, 32'sd701, 32'sd1);
    push_reading(16'd8999, 32'sd1000, 32'sd1000, 32'sd1000);
    push_reading(16'd9001, 32'sd1300, 32'sd1300, 32'sd1300);
    push_reading(16'd17999, 32'sd1600, 32'sd1600, 32'sd1600);
    push_reading(16'd18001, 32'sd1900, 32'sd1900, 32'sd1900);
    push_reading(16'd26999, 32'sd2200, 32'sd2200, 32'sd2200);
    push_reading(16'd27001, 32'sd2500, 32'sd2500, 32'sd2500);
    push_reading(16'd1, 32'sd2501, 32'sd2500, 32'sd2500);
    push_reading(16'd13500, COUNT_MIN, COUNT_MIN, COUNT_MAX);
    push_reading(16'd13500, COUNT_MAX, COUNT_MAX, COUNT_MIN);
    push_reading(16'd31500, COUNT_MIN, COUNT_MAX, COUNT_MAX);
    push_reading(16'd22500, COUNT_MAX, COUNT_MIN, COUNT_MIN);
    push_reading(16'd40000, 32'sd0, 32'sd0, 32'sd0);
    push_reading(16'd0, -32'sd1, 32'sd0, -32'sd1);

    send_idle_pct = 0;
    stall_pct = 0;
    gen_mixed(300);
    gen_runaway(300, 1'b1);
    while (n_sent < 60) begin
      @(posedge clk);
    end
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    wait_idle();

    send_idle_pct = 87;
    stall_pct = 0;
    gen_mixed(350);
    wait_idle();

    send_idle_pct = 0;
    stall_pct = 87;
    gen_mixed(350);
    wait_idle();

    send_idle_pct = 15;
    stall_pct = 15;
    gen_mixed(200);
    gen_runaway(300, 1'b0);
    gen_mixed(150);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pos_expect_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/twodo_pkg.sv
design/twodo_front.sv
design/twodo_queue.sv
design/twodo_back.sv
design/tracking_wheel_odometry_unit.sv
tb/sv/tracking_wheel_odometry_unit_test.sv
